// ===== hw/rtl/mpcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpcd_pkg
// shared types and constants for the mean pairwise codon distance block
// ----------------------------------------------------------------------------
package mpcd_pkg;

  // configuration register widths and indexes
  localparam int TAXON_REG_W = 7;
  localparam int SITE_REG_W  = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAXON_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SITE_COUNT  = 1'b1;

  // payload widths
  localparam int CODON_W    = 6;
  localparam int CELL_W     = CODON_W + 1;
  localparam int FRAC_W     = 16;
  localparam int MEAN_W     = FRAC_W + 1;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // controller to datapath commands
  typedef struct packed {
    logic load_we;
    logic walk_init;
    logic pair_clr;
    logic rd_issue;
    logic div_frac;
    logic div_mean;
    logic acc_frac;
    logic acc_zero;
    logic next_pair;
    logic out_load;
  } mpcd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic site_last;
    logic tot_zero;
    logic walk_last;
    logic div_busy;
    logic div_done;
  } mpcd_sts_t;

endpackage

// ===== hw/rtl/mean_pairwise_codon_distance.sv =====
// ----------------------------------------------------------------------------
// mean_pairwise_codon_distance
// mean pairwise p-distance over a codon alignment, Q1.16 result
// ----------------------------------------------------------------------------
// cells stream in one beat per cycle, taxon by taxon and site by site, and
// are written to an on-chip store at the running load position; cells past
// the store depth are dropped. the beat with tlast starts the pair walk and
// input stays stalled until its result has been placed in the output
// register. for each pair of taxa the two rows are read in parallel, one
// site per cycle through the store's two read ports, and the jointly known
// and differing sites are counted; a shared one-bit-per-cycle divider then
// forms the Q1.16 fraction, and at the end the same divider takes the mean
// over all pairs. a pair with no jointly known site adds zero and sets the
// flag in tuser. the walk covers P = T*(T-1)/2 pairs of S sites each; its
// throughput is set by the per-pair site reads and by the divider, whose
// width DW is 28 at default sizes.
// sizes are saturated to 2..MAX_TAXA and 1..MAX_SITES when tlast arrives.
// the store has no reset; cells that were never loaded must not be read.
// configuration must be written only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module mean_pairwise_codon_distance #(
  parameter int MAX_TAXA  = 64,
  parameter int MAX_SITES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [mpcd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [mpcd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // cell beats
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mpcd_pkg::IN_DATA_W-1:0]      in_tdata,   // [5:0] codon_state, rest zero
  input  logic                                in_tuser,   // [0] state_unknown
  input  logic                                in_tlast,   // last_cell
  // result beats
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mpcd_pkg::OUT_DATA_W-1:0]     out_tdata,  // [16:0] mean_difference, rest zero
  output logic                                out_tuser   // [0] empty_pair_seen
);
  import mpcd_pkg::*;

  mpcd_cmd_t         cmd;
  mpcd_sts_t         sts;
  logic [MEAN_W-1:0] mean_difference;

  mpcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mpcd_dp #(
    .MAX_TAXA  (MAX_TAXA),
    .MAX_SITES (MAX_SITES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_codon        (in_tdata[CODON_W-1:0]),
    .in_unknown      (in_tuser),
    .cmd             (cmd),
    .sts             (sts),
    .mean_difference (mean_difference),
    .empty_pair_seen (out_tuser)
  );

  assign out_tdata = OUT_DATA_W'(mean_difference);

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while a beat is pending");

  // the divider is only started when idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_frac || cmd.div_mean) |-> !sts.div_busy)
    else $error("divider started while busy");

  // a new result beat only follows a result load
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.out_load))
    else $error("out_tvalid rose without a result load");

  // no store reads while cells are still being taken
  a_no_read_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.rd_issue)
    else $error("pair walk read while input is open");

endmodule

// ===== hw/rtl/mpcd_div.sv =====
// ----------------------------------------------------------------------------
// mpcd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mpcd_div #(
  parameter int DDW = 28,
  parameter int DVW = 11
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DDW-1:0] dividend,
  input  logic [DVW-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [DDW-1:0] quotient
);
  localparam int CW = $clog2(DDW + 1);

  logic [DDW-1:0] q_r, q_nxt;
  logic [DVW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] dvs_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DVW:0]   rem_sh;
  logic [DVW:0]   rem_sub;
  logic           ge;

  always_comb begin
    rem_sh  = {rem_r, q_r[DDW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DDW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[DDW-2:0], ge};
      rem_nxt = ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== hw/rtl/mpcd_dp.sv =====
// ----------------------------------------------------------------------------
// mpcd_dp
// alignment store, pair walk counters, match counters, accumulator, divider
// ----------------------------------------------------------------------------
module mpcd_dp #(
  parameter int MAX_TAXA  = 64,
  parameter int MAX_SITES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mpcd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [mpcd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [mpcd_pkg::CODON_W-1:0]       in_codon,
  input  logic                               in_unknown,
  input  mpcd_pkg::mpcd_cmd_t                cmd,
  output mpcd_pkg::mpcd_sts_t                sts,
  output logic [mpcd_pkg::MEAN_W-1:0]        mean_difference,
  output logic                               empty_pair_seen
);
  import mpcd_pkg::*;

  localparam int DEPTH = MAX_TAXA * MAX_SITES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LPW   = $clog2(DEPTH + 1);
  localparam int TW    = $clog2(MAX_TAXA + 1);
  localparam int SW    = $clog2(MAX_SITES + 1);
  localparam int PRW   = $clog2(MAX_TAXA * (MAX_TAXA - 1) / 2 + 1);
  localparam int ACCW  = PRW + MEAN_W;
  localparam int DVW   = (SW > PRW) ? SW : PRW;
  localparam int DDW   = (ACCW > SW + FRAC_W) ? ACCW : SW + FRAC_W;

  // configuration registers
  logic [TAXON_REG_W-1:0] taxon_cfg_r;
  logic [SITE_REG_W-1:0]  site_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taxon_cfg_r <= TAXON_REG_W'(2);
      site_cfg_r  <= SITE_REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TAXON_COUNT: taxon_cfg_r <= cfg_wdata[TAXON_REG_W-1:0];
        CFG_SITE_COUNT:  site_cfg_r  <= cfg_wdata[SITE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated sizes
  logic [31:0]   taxon_ext, site_ext;
  logic [TW-1:0] taxa_sat;
  logic [SW-1:0] sites_sat;

  always_comb begin
    taxon_ext = 32'(taxon_cfg_r);
    site_ext  = 32'(site_cfg_r);
    priority if (taxon_ext < 32'd2) begin
      taxa_sat = TW'(2);
    end else if (taxon_ext > 32'(MAX_TAXA)) begin
      taxa_sat = TW'(MAX_TAXA);
    end else begin
      taxa_sat = taxon_ext[TW-1:0];
    end
    priority if (site_ext < 32'd1) begin
      sites_sat = SW'(1);
    end else if (site_ext > 32'(MAX_SITES)) begin
      sites_sat = SW'(MAX_SITES);
    end else begin
      sites_sat = site_ext[SW-1:0];
    end
  end

  // alignment store
  logic [CELL_W-1:0] mem [DEPTH];
  logic [LPW-1:0]    lpos_r;
  logic [CELL_W-1:0] qa_r, qb_r;
  logic              rv_r;
  logic [LPW-1:0]    addr_a, addr_b;

  always_ff @(posedge clk) begin
    if (cmd.load_we && (lpos_r < LPW'(DEPTH))) begin
      mem[lpos_r[AW-1:0]] <= {in_unknown, in_codon};
    end
    qa_r <= mem[addr_a[AW-1:0]];
    qb_r <= mem[addr_b[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpos_r <= '0;
    end else if (cmd.walk_init) begin
      lpos_r <= '0;
    end else if (cmd.load_we && (lpos_r < LPW'(DEPTH))) begin
      lpos_r <= lpos_r + 1'b1;
    end
  end

  // pair walk
  logic [TW-1:0]   taxa_r, ta_r, tb_r;
  logic [SW-1:0]   sites_r, site_r;
  logic [LPW-1:0]  base_a_r, base_b_r;
  logic [SW-1:0]   tot_r, diff_r;
  logic [PRW-1:0]  pcnt_r;
  logic [ACCW-1:0] acc_r;
  logic            flag_r;
  logic            tb_last;
  logic [LPW-1:0]  sites_l;

  assign sites_l = LPW'(sites_r);
  assign addr_a  = base_a_r + LPW'(site_r);
  assign addr_b  = base_b_r + LPW'(site_r);
  assign tb_last = (tb_r == TW'(taxa_r - 1'b1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= cmd.rd_issue;
    end
  end

  // divider
  logic           div_start;
  logic [DDW-1:0] div_dvd;
  logic [DVW-1:0] div_dvs;
  logic [DDW-1:0] div_q;
  logic           div_busy, div_done;

  assign div_start = cmd.div_frac | cmd.div_mean;
  assign div_dvd   = cmd.div_mean ? DDW'(acc_r) : DDW'({diff_r, {FRAC_W{1'b0}}});
  assign div_dvs   = cmd.div_mean ? DVW'(pcnt_r) : DVW'(tot_r);

  mpcd_div #(
    .DDW (DDW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      taxa_r   <= taxa_sat;
      sites_r  <= sites_sat;
      ta_r     <= '0;
      tb_r     <= TW'(1);
      base_a_r <= '0;
      base_b_r <= LPW'(sites_sat);
      acc_r    <= '0;
      flag_r   <= 1'b0;
      pcnt_r   <= '0;
    end else begin
      if (cmd.next_pair) begin
        if (tb_last) begin
          ta_r     <= ta_r + 1'b1;
          tb_r     <= ta_r + TW'(2);
          base_a_r <= base_a_r + sites_l;
          base_b_r <= base_a_r + (sites_l << 1);
        end else begin
          tb_r     <= tb_r + 1'b1;
          base_b_r <= base_b_r + sites_l;
        end
      end
      if (cmd.acc_frac) begin
        acc_r  <= acc_r + ACCW'(div_q[MEAN_W-1:0]);
        pcnt_r <= pcnt_r + 1'b1;
      end
      if (cmd.acc_zero) begin
        flag_r <= 1'b1;
        pcnt_r <= pcnt_r + 1'b1;
      end
    end
    if (cmd.pair_clr) begin
      site_r <= '0;
      tot_r  <= '0;
      diff_r <= '0;
    end else begin
      if (cmd.rd_issue) begin
        site_r <= site_r + 1'b1;
      end
      if (rv_r && !qa_r[CELL_W-1] && !qb_r[CELL_W-1]) begin
        tot_r <= tot_r + 1'b1;
        if (qa_r[CODON_W-1:0] != qb_r[CODON_W-1:0]) begin
          diff_r <= diff_r + 1'b1;
        end
      end
    end
  end

  // result register
  logic [MEAN_W-1:0] mean_r;
  logic              empty_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_r  <= div_q[MEAN_W-1:0];
      empty_r <= flag_r;
    end
  end

  assign mean_difference = mean_r;
  assign empty_pair_seen = empty_r;

  always_comb begin
    sts.site_last = (site_r == SW'(sites_r - 1'b1));
    sts.tot_zero  = (tot_r == '0);
    sts.walk_last = tb_last && (ta_r == TW'(taxa_r - TW'(2)));
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
  end

endmodule

// ===== hw/rtl/mpcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpcd_ctrl
// sequencer for loading, the pair walk, the divisions and the result beat
// ----------------------------------------------------------------------------
module mpcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output mpcd_pkg::mpcd_cmd_t cmd,
  input  mpcd_pkg::mpcd_sts_t sts
);
  import mpcd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_PCLR  = 4'd2;
  localparam logic [3:0] S_SITE  = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_EVAL  = 4'd5;
  localparam logic [3:0] S_FWAIT = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_MWAIT = 4'd8;
  localparam logic [3:0] S_OUTW  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       in_beat;

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.load_we = in_beat;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat && in_tlast) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = S_PCLR;
      end
      S_PCLR: begin
        cmd.pair_clr = 1'b1;
        state_nxt    = S_SITE;
      end
      S_SITE: begin
        cmd.rd_issue = 1'b1;
        if (sts.site_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_EVAL;
      S_EVAL: begin
        if (sts.tot_zero) begin
          cmd.acc_zero = 1'b1;
          state_nxt    = S_NEXT;
        end else begin
          cmd.div_frac = 1'b1;
          state_nxt    = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (sts.div_done) begin
          cmd.acc_frac = 1'b1;
          state_nxt    = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts.walk_last) begin
          cmd.div_mean = 1'b1;
          state_nxt    = S_MWAIT;
        end else begin
          cmd.next_pair = 1'b1;
          state_nxt     = S_PCLR;
        end
      end
      S_MWAIT: begin
        if (sts.div_done) begin
          state_nxt = S_OUTW;
        end
      end
      S_OUTW: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for mean_pairwise_codon_distance
// ----------------------------------------------------------------------------
// alignments stream in as cell beats, and each one is closed by a tlast beat.
// a shadow copy of the store and the size registers predicts the mean
// pairwise difference and the empty pair flag of every alignment. it starts
// with a short table of directed cells, then runs the widest taxon count and
// random alignments. the sender idles in bursts and the receiver stalls on
// its own pattern.
// ----------------------------------------------------------------------------
module testbench;
  import mpcd_pkg::*;

  localparam int MAX_TAXA    = 64;
  localparam int MAX_SITES   = 1024;
  localparam int STORE_DEPTH = MAX_TAXA * MAX_SITES;
  localparam int IDLE_LIMIT  = 400000;
  localparam int SETTLE_CYC  = 40;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic              empty_pair;
  } distance_t;

  // one row of the directed table; sizes are written when cfg_en is set
  typedef struct {
    bit         cfg_en;
    int         taxa;
    int         sites;
    int         codon;
    bit         unk;
    bit         last;
    bit         typed;   // use the typed expectation below
    int         mean;
    bit         empty_pair;
  } cell_row_t;

  localparam int DIR_ROWS = 17;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  mean_pairwise_codon_distance #(
    .MAX_TAXA  (MAX_TAXA),
    .MAX_SITES (MAX_SITES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // shadow state of the block
  logic [CELL_W-1:0] shadow_store [STORE_DEPTH];
  bit                shadow_written [STORE_DEPTH];
  int                shadow_pos;
  int                taxa_reg;
  int                sites_reg;

  distance_t   pending_distances [$];
  cell_row_t   dir_tbl [DIR_ROWS];
  int          errors;
  int          cells_sent;
  int          alignments;
  int          burst_left;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // store one accepted cell; on the last cell walk every pair of taxa
  function automatic void predict_cell(logic [5:0] codon, logic unk, logic last,
                                       output bit done, output distance_t res);
    int          taxa;
    int          sites;
    longint      frac_sum;
    longint      tot;
    longint      diff;
    longint      pairs;
    bit          empty_pair;
    logic [6:0]  a;
    logic [6:0]  b;
    done = 1'b0;
    res = '0;
    if (shadow_pos < STORE_DEPTH) begin
      shadow_store[shadow_pos] = {unk, codon};
      shadow_written[shadow_pos] = 1'b1;
      shadow_pos++;
    end
    if (!last) return;
    taxa = clamp_int(taxa_reg, 2, MAX_TAXA);
    sites = clamp_int(sites_reg, 1, MAX_SITES);
    frac_sum = 0;
    empty_pair = 1'b0;
    for (int ta = 0; ta < taxa; ta++) begin
      for (int tb = ta + 1; tb < taxa; tb++) begin
        tot = 0;
        diff = 0;
        for (int s = 0; s < sites; s++) begin
          a = shadow_store[ta * sites + s];
          b = shadow_store[tb * sites + s];
          if (!a[6] && !b[6]) begin
            tot++;
            if (a[5:0] != b[5:0]) diff++;
          end
        end
        if (tot == 0) empty_pair = 1'b1;
        else frac_sum += (diff << 16) / tot;
      end
    end
    pairs = longint'(taxa) * (taxa - 1) / 2;
    res.mean = MEAN_W'(frac_sum / pairs);
    res.empty_pair = empty_pair;
    shadow_pos = 0;
    done = 1'b1;
  endfunction

  // sender: bursts of random length with random gaps between them
  task automatic send_cell(logic [5:0] codon, logic unk, logic last,
                           bit typed, distance_t typed_res);
    int        gap;
    bit        done;
    distance_t res;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(0, 4);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, codon};
    in_tuser  <= unk;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    cells_sent++;
    predict_cell(codon, unk, last, done, res);
    if (done) begin
      pending_distances.push_back(typed ? typed_res : res);
      alignments++;
    end
  endtask

  // sizes change only once the block is idle
  task automatic write_sizes(int taxa, int sites);
    in_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_TAXON_COUNT;
    cfg_wdata <= CFG_DATA_W'(taxa);
    @(posedge clk);
    cfg_idx   <= CFG_SITE_COUNT;
    cfg_wdata <= CFG_DATA_W'(sites);
    @(posedge clk);
    cfg_we    <= 1'b0;
    taxa_reg  = taxa & 8'h7f;
    sites_reg = sites & 12'h7ff;
  endtask

  // one alignment with random content; ncells may differ from the size
  task automatic send_alignment(int ncells, int unk_pct, int codon_hi);
    logic [5:0] codon;
    logic       unk;
    for (int i = 0; i < ncells; i++) begin
      codon = 6'($urandom_range(0, codon_hi));
      unk = ($urandom_range(0, 99) < unk_pct);
      send_cell(codon, unk, i == ncells - 1, 1'b0, '0);
    end
  endtask

  // receiver stall pattern: long ready runs, short and long stalls
  always @(posedge clk) begin
    case ($urandom_range(0, 9))
      0, 1:    out_tready <= 1'b0;
      default: out_tready <= 1'b1;
    endcase
  end

  // result beats against the oldest prediction
  always @(posedge clk) begin
    distance_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_distances.size() == 0) begin
        $display("%0t: unexpected result beat mean=%0d flag=%0b", $time,
                 out_tdata[MEAN_W-1:0], out_tuser);
        errors++;
      end else begin
        want = pending_distances.pop_front();
        if (out_tdata[MEAN_W-1:0] !== want.mean) begin
          $display("%0t: mean_difference expected %0d actual %0d", $time,
                   want.mean, out_tdata[MEAN_W-1:0]);
          errors++;
        end
        if (out_tuser !== want.empty_pair) begin
          $display("%0t: empty_pair_seen expected %0b actual %0b", $time,
                   want.empty_pair, out_tuser);
          errors++;
        end
        if (out_tdata[OUT_DATA_W-1:MEAN_W] !== '0) begin
          $display("%0t: tdata pad expected 0 actual %0h", $time,
                   out_tdata[OUT_DATA_W-1:MEAN_W]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int        taxa;
    int        sites;
    int        need;
    int        ncells;
    bit        covered;
    distance_t typed_res;
    errors = 0;
    cells_sent = 0;
    alignments = 0;
    burst_left = 0;
    idle_cycles = 0;
    shadow_pos = 0;
    taxa_reg = 2;
    sites_reg = 1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_TAXON_COUNT;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;

    // identical pair, full difference, an unknown cell, clamped sizes,
    // three taxa by two sites, and a short alignment over old cells
    dir_tbl = '{
      '{1, 2, 1,  5, 0, 0, 0, 0,     0},
      '{0, 0, 0,  5, 0, 1, 1, 0,     0},
      '{0, 0, 0,  0, 0, 0, 0, 0,     0},
      '{0, 0, 0, 63, 0, 1, 1, 65536, 0},
      '{0, 0, 0,  7, 1, 0, 0, 0,     0},
      '{0, 0, 0,  7, 0, 1, 1, 0,     1},
      '{1, 0, 0, 63, 0, 0, 0, 0,     0},
      '{0, 0, 0,  0, 0, 1, 1, 65536, 0},
      '{1, 3, 2, 10, 0, 0, 0, 0,     0},
      '{0, 0, 0, 11, 0, 0, 0, 0,     0},
      '{0, 0, 0, 10, 0, 0, 0, 0,     0},
      '{0, 0, 0, 12, 0, 0, 0, 0,     0},
      '{0, 0, 0, 10, 1, 0, 0, 0,     0},
      '{0, 0, 0, 11, 0, 1, 0, 0,     0},
      '{1, 2, 2,  1, 0, 0, 0, 0,     0},
      '{0, 0, 0,  2, 0, 0, 0, 0,     0},
      '{0, 0, 0,  1, 0, 1, 0, 0,     0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].cfg_en) write_sizes(dir_tbl[i].taxa, dir_tbl[i].sites);
      typed_res.mean = MEAN_W'(dir_tbl[i].mean);
      typed_res.empty_pair = dir_tbl[i].empty_pair;
      send_cell(6'(dir_tbl[i].codon), dir_tbl[i].unk, dir_tbl[i].last,
                dir_tbl[i].typed, typed_res);
    end

    // widest taxon count, raw register value past the legal range
    write_sizes(127, 1);
    send_alignment(64, 20, 3);
    write_sizes(64, 1);
    send_alignment(64, 0, 63);

    // random alignments, mostly small
    while (cells_sent < 700) begin
      taxa = $urandom_range(2, 6);
      sites = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0: taxa = $urandom_range(0, 1);
        1: sites = 0;
        2: taxa = $urandom_range(7, 12);
        default: ;
      endcase
      write_sizes(taxa, sites);
      need = clamp_int(taxa, 2, MAX_TAXA) * clamp_int(sites, 1, MAX_SITES);
      ncells = need;
      if ($urandom_range(0, 3) == 0) ncells = need + $urandom_range(0, 6) - 3;
      if (ncells < 1) ncells = 1;
      // a short alignment is fine only over cells loaded before
      covered = 1'b1;
      for (int a = ncells; a < need; a++) covered &= shadow_written[a];
      if (!covered) ncells = need;
      send_alignment(ncells, ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(0, 30),
                     ($urandom_range(0, 1) == 0) ? 3 : 63);
    end

    in_tvalid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("covered %0d alignments from %0d cell beats, sizes clamped at both ends",
             alignments, cells_sent);
    $display("including all-pairs walks over 64 taxa and short alignments over older cells");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mpcd_pkg.sv
hw/rtl/mpcd_div.sv
hw/rtl/mpcd_dp.sv
hw/rtl/mpcd_ctrl.sv
hw/rtl/mean_pairwise_codon_distance.sv
tb/testbench.sv
